### hdl/swdp_pkg.sv
// Shared types and constants for the stepper wave-drive positioner.
// No dependencies; imported by stepper_wave_drive_positioner.
`timescale 1ns / 1ps

package swdp_pkg;

   localparam int TARGET_W = 9;
   localparam int COIL_W   = 4;
   localparam int ANGLE_W  = 10;
   localparam int COUNT_W  = 16;
   localparam int DEG_W    = 9;
   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 24;

   localparam logic [DEG_W-1:0] DEG_PER_REV = DEG_W'(360);
   localparam logic [COUNT_W-1:0] COUNT_MIN = 16'h8000;
   localparam logic [1:0] LAST_PHASE = 2'd3;

   typedef enum logic [1:0] {
      DIR_CCW  = 2'd0,
      DIR_CW   = 2'd1,
      DIR_HOLD = 2'd2
   } direction_type;

endpackage

### hdl/stepper_wave_drive_positioner.sv
// Stepper wave-drive positioner: steps a unipolar motor toward a target angle.
// Depends on swdp_pkg.
`timescale 1ns / 1ps

// Each accepted word carries a target angle in whole degrees and yields exactly
// one result word in the next cycle: the coil levels, a done flag, the direction
// taken and the whole-degree angle after the step. The block takes one word per
// cycle; throughput is set by the single register stage that holds the position
// state, and a result waiting on a stalled output blocks the input until taken.
// Clockwise steps walk coils A,B,C,D and counter-clockwise steps walk D,C,B,A,
// each with its own phase. Every fourth phase moves the position count by one
// unit of 360/PASSES_PER_REV degree. The angle is tracked incrementally as a
// magnitude in degrees (mod 360) plus a remainder, so no divider is needed; the
// sign follows the position count. Target angles above 359 are never reached.
module stepper_wave_drive_positioner #(
   parameter int PASSES_PER_REV = 512
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // [8:0] target_angle, [15:9] zero
   input  logic [swdp_pkg::REQ_DATA_W-1:0] req_tdata,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // [3:0] coil_drive, [4] done_res, [6:5] direction, [16:7] angle_now,
   // [23:17] zero
   output logic [swdp_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import swdp_pkg::*;

   localparam int RB = (PASSES_PER_REV > 1) ? $clog2(PASSES_PER_REV) : 1;
   localparam int SW = RB + 1;
   localparam int DEG_STEP = 360 / PASSES_PER_REV;
   localparam int REM_STEP = 360 % PASSES_PER_REV;
   localparam logic [SW-1:0] REM_STEP_S = SW'(REM_STEP);
   localparam logic [SW-1:0] PASSES_S = SW'(PASSES_PER_REV);
   localparam logic [SW-1:0] REM_BACK_S = SW'(PASSES_PER_REV - REM_STEP);
   localparam logic [ANGLE_W-1:0] DEG_STEP_A = ANGLE_W'(DEG_STEP);
   localparam logic [ANGLE_W-1:0] FULL_TURN = ANGLE_W'(360);

   logic [COUNT_W-1:0] count_ff, count_in;
   logic [DEG_W-1:0]   mag_ff, mag_in;
   logic [RB-1:0]      rem_ff, rem_in;
   logic [1:0]         cw_phase_ff, cw_phase_in;
   logic [1:0]         ccw_phase_ff, ccw_phase_in;
   logic [COIL_W-1:0]  coil_ff, coil_in;
   logic               rsp_valid_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic                     accept;
   logic [TARGET_W-1:0]      target;
   logic signed [ANGLE_W-1:0] angle_cur, angle_new, angle_out;
   logic signed [ANGLE_W:0]  angle_cmp, target_cmp;
   logic                     step_up, step_dn, pass_done, grow;
   direction_type            dir;
   logic [SW-1:0]            rem_ext, rem_sum, rem_up, rem_dn;
   logic                     carry, borrow;
   logic [ANGLE_W-1:0]       mag_ext, deg_sum, deg_up, deg_sub, deg_dn, mag_new_ext;

   assign req_tready = ~rsp_valid_ff | rsp_tready;
   assign accept     = req_tvalid & req_tready;
   assign target     = req_tdata[TARGET_W-1:0];

   always_comb begin
      mag_ext   = {1'b0, mag_ff};
      angle_cur = count_ff[COUNT_W-1] ? signed'(ANGLE_W'(0) - mag_ext) : signed'(mag_ext);
      angle_cmp  = {angle_cur[ANGLE_W-1], angle_cur};
      target_cmp = signed'({2'b00, target});
      step_up = angle_cmp < target_cmp;
      step_dn = angle_cmp > target_cmp;

      // Moving the count away from zero grows the magnitude. The count is
      // continuous in magnitude across the 16-bit wrap, except that stepping
      // down from the most negative value shrinks it.
      if (step_up) begin
         grow = ~count_ff[COUNT_W-1];
      end else if (count_ff[COUNT_W-1]) begin
         grow = (count_ff != COUNT_MIN);
      end else begin
         grow = (count_ff == '0);
      end

      rem_ext = {1'b0, rem_ff};
      rem_sum = rem_ext + REM_STEP_S;
      carry   = rem_sum >= PASSES_S;
      rem_up  = carry ? rem_sum - PASSES_S : rem_sum;
      deg_sum = mag_ext + DEG_STEP_A + ANGLE_W'(carry);
      deg_up  = (deg_sum >= FULL_TURN) ? deg_sum - FULL_TURN : deg_sum;

      borrow  = rem_ext < REM_STEP_S;
      rem_dn  = borrow ? rem_ext + REM_BACK_S : rem_ext - REM_STEP_S;
      deg_sub = DEG_STEP_A + ANGLE_W'(borrow);
      deg_dn  = (mag_ext < deg_sub) ? mag_ext + FULL_TURN - deg_sub : mag_ext - deg_sub;

      count_in     = count_ff;
      mag_in       = mag_ff;
      rem_in       = rem_ff;
      cw_phase_in  = cw_phase_ff;
      ccw_phase_in = ccw_phase_ff;
      coil_in      = coil_ff;
      pass_done    = 1'b0;
      dir          = DIR_HOLD;

      if (step_up) begin
         dir         = DIR_CW;
         coil_in     = COIL_W'(1) << cw_phase_ff;
         pass_done   = (cw_phase_ff == LAST_PHASE);
         cw_phase_in = cw_phase_ff + 2'd1;
      end else if (step_dn) begin
         dir          = DIR_CCW;
         coil_in      = COIL_W'(8) >> ccw_phase_ff;
         pass_done    = (ccw_phase_ff == LAST_PHASE);
         ccw_phase_in = ccw_phase_ff + 2'd1;
      end

      if (pass_done) begin
         count_in = step_up ? count_ff + 16'd1 : count_ff - 16'd1;
         mag_in   = grow ? deg_up[DEG_W-1:0] : deg_dn[DEG_W-1:0];
         rem_in   = grow ? rem_up[RB-1:0] : rem_dn[RB-1:0];
      end

      mag_new_ext = {1'b0, mag_in};
      angle_new = count_in[COUNT_W-1] ? signed'(ANGLE_W'(0) - mag_new_ext)
                                      : signed'(mag_new_ext);
      angle_out = pass_done ? angle_new : angle_cur;

      rsp_data_in = {7'd0, angle_out, dir, (dir == DIR_HOLD), coil_in};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         mag_ff       <= '0;
         rem_ff       <= '0;
         cw_phase_ff  <= '0;
         ccw_phase_ff <= '0;
         coil_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            count_ff     <= count_in;
            mag_ff       <= mag_in;
            rem_ff       <= rem_in;
            cw_phase_ff  <= cw_phase_in;
            ccw_phase_ff <= ccw_phase_in;
            coil_ff      <= coil_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // The tracked magnitude and remainder stay in range.
   a_mag_range: assert property (@(posedge clock) disable iff (reset)
      (mag_ff < DEG_PER_REV) && ({1'b0, rem_ff} < PASSES_S))
      else $error("angle magnitude or remainder out of range");

   // A zero count always carries a zero angle and remainder.
   a_zero_count: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> (mag_ff == '0) && (rem_ff == '0))
      else $error("zero position with nonzero angle state");

   // A step result drives exactly one coil and is never marked done.
   a_step_coil: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_data_ff[6:5] != DIR_HOLD))
         |-> $onehot(rsp_data_ff[3:0]) && !rsp_data_ff[4])
      else $error("step result with bad coil pattern or done flag");

   // A step without a completed pass leaves the position untouched.
   a_count_hold: assert property (@(posedge clock) disable iff (reset)
      (accept && !pass_done) |=> $stable(count_ff) && $stable(mag_ff))
      else $error("position moved without a completed pass");

endmodule
